@@ rtl/core/nelc_pkg.sv @@
// ----------------------------------------------------------------------------
// nelc_pkg: shared constants for the nested envelope chain block
// Holds default sizes and the chain length limit.
// ----------------------------------------------------------------------------
package nelc_pkg;
	localparam int MaxEnvelopes = 64;
	localparam int DimBits      = 16;
	localparam int ChainBits    = 7;
	localparam logic [ChainBits-1:0] ChainMax = 7'd127;
endpackage

@@ rtl/core/nelc_if.sv @@
// ----------------------------------------------------------------------------
// nelc_if: valid/ready channel
// Carries one payload word of parametric width with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface nelc_if #(parameter int W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/nelc_ram.sv @@
// ----------------------------------------------------------------------------
// nelc_ram: generic single-port-write, one-read RAM
// Write at one address, read at another, read data registered.
// ----------------------------------------------------------------------------
module nelc_ram #(
	parameter int W = 8,
	parameter int D = 64,
	parameter int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [D];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/core/nelc_front.sv @@
// ----------------------------------------------------------------------------
// nelc_front: envelope intake
// Accepts envelope words, counts them, flags overflow and passes each word
// that is kept, or the end-of-set marker, into a short queue.
// ----------------------------------------------------------------------------
module nelc_front #(
	parameter int N = nelc_pkg::MaxEnvelopes,
	parameter int D = nelc_pkg::DimBits,
	parameter int QW = 2*D + 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [D-1:0]  in_w,
	input  logic [D-1:0]  in_h,
	input  logic          in_last,
	output logic          q_valid,
	input  logic          q_ready,
	output logic [QW-1:0] q_data
);
	localparam int CW = $clog2(N+1);
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic          full;
	logic          acc;
	logic [1:0]    fill_q;
	logic [QW-1:0] slot_q [2];
	logic          rd_q, wr_q;
	logic          push, pop;
	logic [QW-1:0] word;

	assign full = (count_q == CW'(N));
	assign in_ready = (fill_q != 2'd2);
	assign acc = in_valid && in_ready;
	// word: {last, overflow, w, h}; a dropped non-last word is not queued
	assign word = {in_last, ovf_q | full, in_w, in_h};
	assign push = acc && (!full || in_last);
	assign q_valid = (fill_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_data = slot_q[rd_q];

	// track count and overflow per set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (acc) begin
			if (in_last) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (full) ovf_q <= 1'b1;
			else count_q <= count_q + 1'b1;
		end
	end

	// two-entry queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			rd_q   <= 1'b0;
			wr_q   <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= word;
	end

	assert property (@(posedge clk) disable iff (!arst_n) fill_q <= 2'd2)
		else $error("queue fill out of range");
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(N))
		else $error("count beyond capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		(acc && in_last) |=> (count_q == '0 && !ovf_q))
		else $error("set state not cleared");
endmodule

@@ rtl/core/nelc_back.sv @@
// ----------------------------------------------------------------------------
// nelc_back: sort and chain engine
// Inserts each envelope into a sorted list (descending width, then height),
// then runs the quadratic chain program over the list and emits the result.
// ----------------------------------------------------------------------------
module nelc_back #(
	parameter int N = nelc_pkg::MaxEnvelopes,
	parameter int D = nelc_pkg::DimBits,
	parameter int QW = 2*D + 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_ready,
	input  logic [QW-1:0] q_data,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [nelc_pkg::ChainBits-1:0] out_len,
	output logic          out_ovf
);
	localparam int AW = (N > 1) ? $clog2(N) : 1;
	localparam int CW = $clog2(N+1);
	localparam int LW = nelc_pkg::ChainBits;
	// insertion sort runs in place in flop-free memories: shift from top down

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_SHIFT = 7'b0000010,
		S_PUT   = 7'b0000100,
		S_IRD   = 7'b0001000,
		S_JCMP  = 7'b0010000,
		S_IWR   = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t state_q;
	logic [CW-1:0] n_q, j_q, i_q;
	logic [D-1:0]  nw_q, nh_q, wi_q, hi_q;
	logic          last_q, ovf_q, vld_q;
	logic [LW:0]   len_q, best_q;
	logic [LW-1:0] res_q;
	logic          ores_ovf_q, out_valid_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [D-1:0]  w_wd, h_wd, w_rd, h_rd;
	logic [LW-1:0] b_wd, b_rd;
	logic          b_we;
	logic [AW-1:0] b_waddr;

	nelc_ram #(.W(D), .D(N)) u_w (.clk, .we, .waddr, .wdata(w_wd), .raddr, .rdata(w_rd));
	nelc_ram #(.W(D), .D(N)) u_h (.clk, .we, .waddr, .wdata(h_wd), .raddr, .rdata(h_rd));
	nelc_ram #(.W(LW), .D(N)) u_b (.clk, .we(b_we), .waddr(b_waddr), .wdata(b_wd),
		.raddr, .rdata(b_rd));

	logic goes_first;   // new entry sorts ahead of the entry just read
	assign goes_first = (nw_q != w_rd) ? (nw_q > w_rd) : (nh_q > h_rd);

	assign q_ready = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_len = res_q;
	assign out_ovf = ores_ovf_q;

	// memory addressing per state
	always_comb begin
		we = 1'b0; waddr = j_q[AW-1:0]; w_wd = nw_q; h_wd = nh_q;
		raddr = '0; b_we = 1'b0; b_waddr = i_q[AW-1:0];
		b_wd = (len_q > (LW+1)'(nelc_pkg::ChainMax)) ? nelc_pkg::ChainMax : len_q[LW-1:0];
		case (state_q)
			S_IDLE:  raddr = AW'(n_q - 1'b1);
			S_SHIFT: begin
				// read data is entry j-1; move it up or place new entry
				we = 1'b1;
				if (vld_q && goes_first) begin
					w_wd = w_rd; h_wd = h_rd;
				end
				raddr = AW'(j_q - 2'd2);
			end
			S_IRD:   raddr = i_q[AW-1:0];
			S_JCMP:  raddr = AW'(j_q + 1'b1);
			S_IWR:   begin
				b_we = 1'b1;
				raddr = AW'(i_q + 1'b1);
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; n_q <= '0; out_valid_q <= 1'b0;
			j_q <= '0; i_q <= '0; vld_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (q_valid && q_ready) begin
					{last_q, ovf_q, nw_q, nh_q} <= q_data;
					if (q_data[QW-2] && n_q == CW'(N)) begin
						state_q <= S_IRD; i_q <= '0; best_q <= '0;
					end else begin
						j_q <= n_q; vld_q <= (n_q != '0);
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (vld_q && goes_first) begin
						j_q <= j_q - 1'b1; vld_q <= (j_q > CW'(1));
					end else begin
						// entry placed at j
						n_q <= n_q + 1'b1;
						if (last_q) begin
							state_q <= S_IRD; i_q <= '0; best_q <= '0;
						end else state_q <= S_IDLE;
					end
				end
				S_IRD: begin
					// read of entry i under way
					state_q <= S_PUT;
				end
				S_PUT: begin
					wi_q <= w_rd; hi_q <= h_rd; len_q <= (LW+1)'(1);
					j_q <= '0;
					if (i_q == '0) state_q <= S_IWR;
					else state_q <= S_JCMP;
				end
				S_JCMP: begin
					// data of entry j present in this cycle
					if (wi_q < w_rd && hi_q < h_rd && ({1'b0, b_rd} + 1'b1) > len_q)
						len_q <= {1'b0, b_rd} + 1'b1;
					if (j_q + 1'b1 == i_q) state_q <= S_IWR;
					j_q <= j_q + 1'b1;
				end
				S_IWR: begin
					if (len_q > best_q) best_q <= len_q;
					if (i_q + 1'b1 == n_q) state_q <= S_OUT;
					else state_q <= S_IRD;
					i_q <= i_q + 1'b1;
				end
				S_OUT: if (!out_valid_q) begin
					res_q <= (best_q > (LW+1)'(nelc_pkg::ChainMax)) ?
						nelc_pkg::ChainMax : best_q[LW-1:0];
					ores_ovf_q <= ovf_q;
					out_valid_q <= 1'b1;
					n_q <= '0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) n_q <= CW'(N))
		else $error("stored count beyond capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_JCMP) |-> (j_q < i_q))
		else $error("inner index passed outer index");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && !out_valid_q) |=> out_valid_q)
		else $error("result not raised");
endmodule

@@ rtl/core/nested_envelope_longest_chain_top.sv @@
// ----------------------------------------------------------------------------
// nested_envelope_longest_chain_top: longest nested envelope chain
// Front takes envelope words into a two-word queue; back sorts and chains.
//
//   channel | dir | payload
//   env     | in  | env_width, env_height, last_envelope
//   chain   | out | chain_length, overflowed
//
// Loading an envelope moves each stored entry that it passes up by one
// (insertion sort, one memory read and write a cycle).
// The chain pass after the last word compares each stored envelope with
// each earlier one, a pair at a time in the shared RAM-port compare step.
// Reset clears counts and control; the stores need no clearing.
// The result register holds until taken; meanwhile the front takes words
// until its two-word queue is full (dropped overflow words need no slot).
// ----------------------------------------------------------------------------
module nested_envelope_longest_chain_top #(
	parameter int MAX_ENVELOPES = nelc_pkg::MaxEnvelopes,
	parameter int DIM_BITS      = nelc_pkg::DimBits
) (
	input logic clk,
	input logic arst_n,
	nelc_if.sink   env,
	nelc_if.source chain
);
	localparam int QW = 2*DIM_BITS + 2;
	logic          q_valid, q_ready;
	logic [QW-1:0] q_data;

	nelc_front #(.N(MAX_ENVELOPES), .D(DIM_BITS), .QW(QW)) u_front (
		.clk, .arst_n,
		.in_valid(env.valid), .in_ready(env.ready),
		.in_w(env.data[2*DIM_BITS:DIM_BITS+1]), .in_h(env.data[DIM_BITS:1]),
		.in_last(env.data[0]),
		.q_valid, .q_ready, .q_data
	);

	nelc_back #(.N(MAX_ENVELOPES), .D(DIM_BITS), .QW(QW)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_data,
		.out_valid(chain.valid), .out_ready(chain.ready),
		.out_len(chain.data[nelc_pkg::ChainBits:1]), .out_ovf(chain.data[0])
	);
endmodule

@@ bench/nelc_tb_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nelc_tb_pkg: word layouts for the envelope chain bench
// Field order of the env and chain words, first field in the top bits.
// ----------------------------------------------------------------------------
package nelc_tb_pkg;
	import nelc_pkg::*;

	localparam int EnvWordBits   = 2 * DimBits + 1;
	localparam int ChainWordBits = ChainBits + 1;

	typedef struct packed {
		logic [DimBits-1:0] env_width;
		logic [DimBits-1:0] env_height;
		logic               last_envelope;
	} env_word_t;

	typedef struct packed {
		logic [ChainBits-1:0] chain_length;
		logic                 overflowed;
	} chain_word_t;
endpackage

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: nested envelope longest chain
// Streams envelope sets through the block, predicts each chain length and
// overflow flag from its own copy of the set, and compares every result word.
// ----------------------------------------------------------------------------
module testbench;
	import nelc_pkg::*;
	import nelc_tb_pkg::*;

	localparam int CycleLimit = 3000000;

	logic clk;
	logic arst_n;

	nelc_if #(.W(EnvWordBits))   env_ch ();
	nelc_if #(.W(ChainWordBits)) chain_ch ();

	nested_envelope_longest_chain_top dut (
		.clk   (clk),
		.arst_n(arst_n),
		.env   (env_ch.sink),
		.chain (chain_ch.source)
	);

	// current set as the block should hold it
	logic [DimBits-1:0] set_width [$];
	logic [DimBits-1:0] set_height [$];
	logic               set_overflow;
	chain_word_t        expected_chains [$];
	int                 mismatches;
	int                 cycle_count;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// gap length: mostly short, a few long, sometimes none
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// longest strictly nested chain over the stored set
	function automatic chain_word_t chain_of_set();
		chain_word_t        res;
		logic [DimBits-1:0] w [$];
		logic [DimBits-1:0] h [$];
		int                 best_at [$];
		int                 n, i, j, best, len;
		logic [DimBits-1:0] tw, th;
		w = set_width;
		h = set_height;
		n = w.size();
		// descending by width, then height
		for (i = 1; i < n; i++) begin
			tw = w[i];
			th = h[i];
			j = i;
			while (j > 0 && (tw > w[j-1] || (tw == w[j-1] && th > h[j-1]))) begin
				w[j] = w[j-1];
				h[j] = h[j-1];
				j--;
			end
			w[j] = tw;
			h[j] = th;
		end
		best = 0;
		for (i = 0; i < n; i++) begin
			len = 1;
			for (j = 0; j < i; j++)
				if (w[i] < w[j] && h[i] < h[j] && best_at[j] + 1 > len)
					len = best_at[j] + 1;
			best_at.push_back(len);
			if (len > best) best = len;
		end
		if (best > ChainMax) best = ChainMax;
		res.chain_length = best[ChainBits-1:0];
		res.overflowed   = set_overflow;
		return res;
	endfunction

	// send one envelope word and update the prediction on acceptance
	task automatic send_envelope(input logic [DimBits-1:0] w, input logic [DimBits-1:0] h,
			input logic last);
		env_word_t word;
		int        gap;
		gap = pick_gap();
		if (gap > 0) begin
			env_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		word.env_width     = w;
		word.env_height    = h;
		word.last_envelope = last;
		env_ch.valid <= 1'b1;
		env_ch.data  <= word;
		@(posedge clk);
		while (!env_ch.ready) @(posedge clk);
		if (set_width.size() < MaxEnvelopes) begin
			set_width.push_back(w);
			set_height.push_back(h);
		end else begin
			set_overflow = 1'b1;
		end
		if (last) begin
			expected_chains.push_back(chain_of_set());
			set_width.delete();
			set_height.delete();
			set_overflow = 1'b0;
		end
	endtask

	// hold the sender until every result has come back
	task automatic drain_results();
		env_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_chains.size() != 0) @(posedge clk);
	endtask

	task automatic test_single_envelopes();
		send_envelope('0, '0, 1'b1);
		send_envelope('1, '1, 1'b1);
		send_envelope(16'h8000, 16'h0001, 1'b1);
	endtask

	task automatic test_nesting_rules();
		// strict chain of five, given out of order
		send_envelope(16'd30, 16'd30, 1'b0);
		send_envelope(16'd10, 16'd10, 1'b0);
		send_envelope(16'd50, 16'd50, 1'b0);
		send_envelope(16'd20, 16'd20, 1'b0);
		send_envelope(16'd40, 16'd40, 1'b1);
		// equal widths and equal heights never nest
		send_envelope(16'd7, 16'd1, 1'b0);
		send_envelope(16'd7, 16'd9, 1'b0);
		send_envelope(16'd3, 16'd9, 1'b0);
		send_envelope(16'd7, 16'd9, 1'b1);
		// extremes of both fields
		send_envelope('0, '1, 1'b0);
		send_envelope('1, '0, 1'b0);
		send_envelope('0, '0, 1'b0);
		send_envelope('1, '1, 1'b1);
	endtask

	task automatic test_full_store();
		int i;
		// exactly full, then full with the last word dropped
		for (i = 0; i < MaxEnvelopes; i++)
			send_envelope(DimBits'(i), DimBits'(i), i == MaxEnvelopes - 1);
		for (i = 0; i < MaxEnvelopes + 3; i++)
			send_envelope(DimBits'($urandom_range(0, 200)), DimBits'($urandom_range(0, 200)),
				i == MaxEnvelopes + 2);
		drain_results();
	endtask

	task automatic test_random_sets(input int items);
		int sent, n, i, r, span;
		sent = 0;
		while (sent < items) begin
			r = $urandom_range(99);
			if (r < 85) n = $urandom_range(1, 12);
			else if (r < 95) n = $urandom_range(13, 40);
			else n = $urandom_range(60, 70);
			span = ($urandom_range(3) == 0) ? 65535 : $urandom_range(4, 60);
			for (i = 0; i < n; i++)
				send_envelope(DimBits'($urandom_range(0, span)), DimBits'($urandom_range(0, span)),
					i == n - 1);
			sent += n;
			if ($urandom_range(49) == 0) drain_results();
		end
	endtask

	// receiver stalls: mostly short, a few long, stretches with none
	initial begin
		int stall;
		chain_ch.ready <= 1'b0;
		forever begin
			stall = pick_gap();
			if (stall > 0) begin
				chain_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			chain_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	// compare each result word with the oldest prediction
	always @(posedge clk) begin
		chain_word_t got, want;
		if (arst_n && chain_ch.valid && chain_ch.ready) begin
			got = chain_ch.data;
			if (expected_chains.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: chain_length=%0d overflowed=%0b",
						got.chain_length, got.overflowed);
			end else begin
				want = expected_chains.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected length=%0d ovf=%0b, got length=%0d ovf=%0b",
							want.chain_length, want.overflowed, got.chain_length, got.overflowed);
				end
			end
		end
	end

	// stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		mismatches   = 0;
		cycle_count  = 0;
		set_overflow = 1'b0;
		arst_n       = 1'b0;
		env_ch.valid = 1'b0;
		env_ch.data  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_envelopes();
		test_nesting_rules();
		test_full_store();
		test_random_sets(2000);
		drain_results();
		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_chains.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
